FILE: sv/led_chaser_key_controller_macros.svh
// Assertion helpers for the LED chaser key controller.
`ifndef LED_CHASER_KEY_CONTROLLER_MACROS_SVH
`define LED_CHASER_KEY_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every clock edge outside reset.
`define LCKC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define LCKC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define LCKC_ASSERT(label, clk, rst_n, prop, msg)
`define LCKC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/lckc_pkg.sv
`default_nettype none

package lckc_pkg;

  localparam int PERIOD_W = 16;
  localparam int LED_W    = 8;
  localparam int KEY_W    = 6;
  localparam int SPEED_W  = 3;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_KEY  = 1'b1
  } op_t;

  localparam logic [1:0] CFG_PERIOD_ONE   = 2'd0;
  localparam logic [1:0] CFG_PERIOD_TWO   = 2'd1;
  localparam logic [1:0] CFG_PERIOD_THREE = 2'd2;
  localparam logic [1:0] CFG_PERIOD_FOUR  = 2'd3;

  localparam logic [PERIOD_W-1:0] PERIOD_ONE_RST   = 16'd500;
  localparam logic [PERIOD_W-1:0] PERIOD_TWO_RST   = 16'd250;
  localparam logic [PERIOD_W-1:0] PERIOD_THREE_RST = 16'd166;
  localparam logic [PERIOD_W-1:0] PERIOD_FOUR_RST  = 16'd125;

  localparam logic [LED_W-1:0] SINGLE_RESET = 8'h01;
  localparam logic [LED_W-1:0] DUAL_RESET   = 8'h81;
  localparam logic [LED_W-1:0] DUAL_MID     = 8'h18;
  localparam logic [LED_W-1:0] DUAL_UPPER   = 8'hF0;
  localparam logic [LED_W-1:0] DUAL_LOWER   = 8'h0F;
  localparam logic [LED_W-1:0] LEDS_OFF     = 8'h00;

  localparam int KEY_RESUME   = 0;
  localparam int KEY_PAUSE    = 1;
  localparam int KEY_FASTER   = 2;
  localparam int KEY_SLOWER   = 3;
  localparam int KEY_DUAL_ON  = 4;
  localparam int KEY_DUAL_OFF = 5;

  localparam logic [KEY_W-1:0] MASK_K1 = 6'h01;
  localparam logic [KEY_W-1:0] MASK_K2 = 6'h02;
  localparam logic [KEY_W-1:0] MASK_K3 = 6'h04;
  localparam logic [KEY_W-1:0] MASK_K4 = 6'h08;

  localparam logic [1:0] TONE_ZERO  = 2'd0;
  localparam logic [1:0] TONE_ONE   = 2'd1;
  localparam logic [1:0] TONE_TWO   = 2'd2;
  localparam logic [1:0] TONE_THREE = 2'd3;

  localparam logic [SPEED_W-1:0] SPEED_MIN = 3'd1;

  typedef struct packed {
    logic [PERIOD_W-1:0] one;
    logic [PERIOD_W-1:0] two;
    logic [PERIOD_W-1:0] three;
    logic [PERIOD_W-1:0] four;
  } periods_t;

  typedef struct packed {
    logic [LED_W-1:0]   leds;
    logic               beep_valid;
    logic [1:0]         beep_tone;
    logic [SPEED_W-1:0] speed_level;
  } result_t;

  function automatic logic [PERIOD_W-1:0] period_sel(periods_t p, logic [SPEED_W-1:0] lvl);
    logic [PERIOD_W-1:0] r;
    priority if (lvl <= 3'd1) r = p.one;
    else if (lvl == 3'd2)     r = p.two;
    else if (lvl == 3'd3)     r = p.three;
    else                      r = p.four;
    return r;
  endfunction

  function automatic logic [1:0] tone_of(logic [KEY_W-1:0] k);
    logic [1:0] t;
    priority if (k == MASK_K1) t = TONE_ZERO;
    else if (k == MASK_K2)     t = TONE_ONE;
    else if (k == MASK_K3)     t = TONE_TWO;
    else if (k == MASK_K4)     t = TONE_THREE;
    else                       t = TONE_ONE;
    return t;
  endfunction

endpackage

`default_nettype wire

FILE: sv/lckc_cfg.sv
`default_nettype none

module lckc_cfg
  import lckc_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [PERIOD_W-1:0] cfg_wdata,
  output periods_t                 periods
);

  periods_t periods_r;
  periods_t periods_nxt;

  always_comb begin
    periods_nxt = periods_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PERIOD_ONE:   periods_nxt.one   = cfg_wdata;
        CFG_PERIOD_TWO:   periods_nxt.two   = cfg_wdata;
        CFG_PERIOD_THREE: periods_nxt.three = cfg_wdata;
        CFG_PERIOD_FOUR:  periods_nxt.four  = cfg_wdata;
        default:          periods_nxt       = periods_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      periods_r.one   <= PERIOD_ONE_RST;
      periods_r.two   <= PERIOD_TWO_RST;
      periods_r.three <= PERIOD_THREE_RST;
      periods_r.four  <= PERIOD_FOUR_RST;
    end else begin
      periods_r <= periods_nxt;
    end
  end

  assign periods = periods_r;

endmodule

`default_nettype wire

FILE: sv/lckc_engine.sv
`default_nettype none

module lckc_engine
  import lckc_pkg::*;
#(
  parameter int MAX_SPEED = 4
)
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             step_en,
  input  wire logic             op,
  input  wire logic [KEY_W-1:0] keys,
  input  periods_t              periods,
  output result_t               result
);

  `include "led_chaser_key_controller_macros.svh"

  localparam logic [SPEED_W-1:0] SPEED_MAX = SPEED_W'(MAX_SPEED);

  logic [LED_W-1:0]    single_r, single_nxt;
  logic [LED_W-1:0]    dual_r, dual_nxt;
  logic                conv_r, conv_nxt;
  logic                paused_r, paused_nxt;
  logic                dual_mode_r, dual_mode_nxt;
  logic [SPEED_W-1:0]  speed_r, speed_nxt;
  logic [PERIOD_W-1:0] tick_r, tick_nxt;
  logic [PERIOD_W-1:0] ilen_r, ilen_nxt;
  logic [LED_W-1:0]    led_r, led_nxt;
  logic [PERIOD_W:0]   tick_inc;
  logic                beep_valid;
  logic [1:0]          beep_tone;

  always_comb begin
    single_nxt    = single_r;
    dual_nxt      = dual_r;
    conv_nxt      = conv_r;
    paused_nxt    = paused_r;
    dual_mode_nxt = dual_mode_r;
    speed_nxt     = speed_r;
    tick_nxt      = tick_r;
    ilen_nxt      = ilen_r;
    led_nxt       = led_r;
    tick_inc      = {1'b0, tick_r} + {{PERIOD_W{1'b0}}, 1'b1};
    beep_valid    = 1'b0;
    beep_tone     = TONE_ZERO;

    unique case (op_t'(op))
      OP_TICK: begin
        if (dual_mode_r || !paused_r) begin
          if (tick_inc >= {1'b0, ilen_r}) begin
            tick_nxt = '0;
            ilen_nxt = period_sel(periods, speed_r);
            if (dual_mode_r) begin
              if (conv_r) begin
                dual_nxt = ((dual_r & DUAL_UPPER) >> 1) | ((dual_r & DUAL_LOWER) << 1);
              end else begin
                dual_nxt = ((dual_r & DUAL_UPPER) << 1) | ((dual_r & DUAL_LOWER) >> 1);
              end
              if (dual_nxt == DUAL_MID || dual_nxt == DUAL_RESET) begin
                conv_nxt = !conv_r;
              end
              led_nxt = dual_nxt;
            end else begin
              single_nxt = single_r << 1;
              if (single_nxt == LEDS_OFF) begin
                single_nxt = SINGLE_RESET;
              end
              led_nxt = single_nxt;
            end
          end else begin
            tick_nxt = tick_inc[PERIOD_W-1:0];
          end
        end
      end
      OP_KEY: begin
        if (keys != '0) begin
          // mask bits act in key order, each seeing the effect of the lower ones
          if (keys[KEY_RESUME] && paused_nxt && !dual_mode_nxt) begin
            paused_nxt = 1'b0;
            led_nxt    = single_nxt;
            tick_nxt   = '0;
            ilen_nxt   = period_sel(periods, speed_nxt);
          end
          if (keys[KEY_PAUSE] && !paused_nxt && !dual_mode_nxt) begin
            paused_nxt = 1'b1;
            led_nxt    = LEDS_OFF;
          end
          if (keys[KEY_FASTER] && speed_nxt < SPEED_MAX) begin
            speed_nxt = speed_nxt + SPEED_MIN;
          end
          if (keys[KEY_SLOWER] && speed_nxt > SPEED_MIN) begin
            speed_nxt = speed_nxt - SPEED_MIN;
          end
          if (keys[KEY_DUAL_ON] && !dual_mode_nxt) begin
            dual_mode_nxt = 1'b1;
            paused_nxt    = 1'b1;
            dual_nxt      = DUAL_RESET;
            conv_nxt      = 1'b1;
            led_nxt       = DUAL_RESET;
            tick_nxt      = '0;
            ilen_nxt      = period_sel(periods, speed_nxt);
          end
          if (keys[KEY_DUAL_OFF] && dual_mode_nxt) begin
            dual_mode_nxt = 1'b0;
            paused_nxt    = 1'b0;
            led_nxt       = single_nxt;
            tick_nxt      = '0;
            ilen_nxt      = period_sel(periods, speed_nxt);
          end
          beep_valid = 1'b1;
          beep_tone  = tone_of(keys);
        end
      end
      default: begin
        beep_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      single_r    <= SINGLE_RESET;
      dual_r      <= DUAL_RESET;
      conv_r      <= 1'b1;
      paused_r    <= 1'b0;
      dual_mode_r <= 1'b0;
      speed_r     <= SPEED_MIN;
      tick_r      <= '0;
      ilen_r      <= PERIOD_ONE_RST;
      led_r       <= SINGLE_RESET;
    end else if (step_en) begin
      single_r    <= single_nxt;
      dual_r      <= dual_nxt;
      conv_r      <= conv_nxt;
      paused_r    <= paused_nxt;
      dual_mode_r <= dual_mode_nxt;
      speed_r     <= speed_nxt;
      tick_r      <= tick_nxt;
      ilen_r      <= ilen_nxt;
      led_r       <= led_nxt;
    end
  end

  assign result.leds        = led_nxt;
  assign result.beep_valid  = beep_valid;
  assign result.beep_tone   = beep_tone;
  assign result.speed_level = speed_nxt;

  `LCKC_ASSERT(a_speed_range, clk, rst_n, (speed_r >= SPEED_MIN && speed_r <= SPEED_MAX), "speed out of range")
  `LCKC_ASSERT(a_single_onehot, clk, rst_n, $onehot(single_r), "single pattern not one-hot")
  `LCKC_ASSERT(a_dual_two_lit, clk, rst_n, ($countones(dual_r) == 2), "dual pattern lost a bit")
  `LCKC_ASSERT(a_tick_bound, clk, rst_n, (tick_r == '0 || tick_r < ilen_r), "tick count past interval")

endmodule

`default_nettype wire

FILE: sv/led_chaser_key_controller.sv
// LED chaser driven by millisecond ticks and debounced key presses.
//
// Input channel (in_valid/in_ready): one item per transfer, in_operation
// selects a tick or a key press, in_keys holds the press mask (K1 in bit 0).
// Result channel (out_valid/out_ready): one result per input item, in order,
// giving the LED drive, the beep request with its tone and the speed level.
// Configuration port: cfg_we writes cfg_wdata into the period register picked
// by cfg_index (ticks per step at speed levels 1 to 4); write only when idle.
//
// An input transfer loads the input register; when the result register is free
// or being taken, the state update runs and loads the result register, which
// then presents the result with out_valid. Throughput is one item per cycle
// while out_ready holds; the state update loop sets it.
// A result that waits on out_ready keeps one more item in the input register;
// in_ready drops only when both registers are full.
// Synchronous reset restores the default periods, speed level 1, the single
// chaser at L1 running, and empties both registers.
`default_nettype none

module led_chaser_key_controller
  import lckc_pkg::*;
#(
  parameter int MAX_SPEED = 4
)
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_ready,
  input  wire logic                in_operation,
  input  wire logic [KEY_W-1:0]    in_keys,
  output      logic                out_valid,
  input  wire logic                out_ready,
  output      logic [LED_W-1:0]    out_leds,
  output      logic                out_beep_valid,
  output      logic [1:0]          out_beep_tone,
  output      logic [SPEED_W-1:0]  out_speed_level,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [PERIOD_W-1:0] cfg_wdata
);

  `include "led_chaser_key_controller_macros.svh"

  logic             s1_valid_r;
  logic             s1_op_r;
  logic [KEY_W-1:0] s1_keys_r;
  logic             out_valid_r;
  result_t          out_r;
  result_t          result;
  periods_t         periods;
  logic             adv;
  logic             in_xfer;

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;
  assign in_xfer  = in_valid && in_ready;

  lckc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .periods   (periods)
  );

  lckc_engine #(
    .MAX_SPEED (MAX_SPEED)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .op      (s1_op_r),
    .keys    (s1_keys_r),
    .periods (periods),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r   <= in_operation;
      s1_keys_r <= in_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= result;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_leds        = out_r.leds;
  assign out_beep_valid  = out_r.beep_valid;
  assign out_beep_tone   = out_r.beep_tone;
  assign out_speed_level = out_r.speed_level;

  `LCKC_ASSERT_NEXT(a_adv_loads_out, clk, rst_n, adv, out_valid_r, "advanced item left no result")
  `LCKC_ASSERT(a_stall_only_full, clk, rst_n, (in_ready || (s1_valid_r && out_valid_r)), "input stalled with room")
  `LCKC_ASSERT(a_silent_tone, clk, rst_n, (!out_valid_r || out_r.beep_valid || out_r.beep_tone == TONE_ZERO), "tone without beep")

endmodule

`default_nettype wire

FILE: bench/led_chaser_key_controller_tb.sv
`default_nettype none

module led_chaser_key_controller_tb;
  import lckc_pkg::*;

  localparam int SPEED_TOP = 4;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_operation = OP_TICK;
  logic [KEY_W-1:0]    in_keys = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [LED_W-1:0]    out_leds;
  logic                out_beep_valid;
  logic [1:0]          out_beep_tone;
  logic [SPEED_W-1:0]  out_speed_level;
  logic                cfg_we = 1'b0;
  logic [1:0]          cfg_index = CFG_PERIOD_ONE;
  logic [PERIOD_W-1:0] cfg_wdata = '0;

  led_chaser_key_controller #(.MAX_SPEED(SPEED_TOP)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_keys(in_keys),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_leds(out_leds), .out_beep_valid(out_beep_valid),
    .out_beep_tone(out_beep_tone), .out_speed_level(out_speed_level),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #2 clk = ~clk;

  // chaser state mirror
  periods_t            periods;
  logic [LED_W-1:0]    pat_single;
  logic [LED_W-1:0]    pat_dual;
  logic                toward_mid;
  logic                is_paused;
  logic                in_dual;
  logic [SPEED_W-1:0]  cur_speed;
  logic [PERIOD_W-1:0] ticks;
  logic [PERIOD_W-1:0] step_len;
  logic [LED_W-1:0]    drive;

  result_t     chaser_results[$];
  result_t     want;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          items_sent = 0;
  int          presses_sent = 0;

  function automatic void restart_interval();
    ticks = '0;
    if (cur_speed <= 3'd1) step_len = periods.one;
    else if (cur_speed == 3'd2) step_len = periods.two;
    else if (cur_speed == 3'd3) step_len = periods.three;
    else step_len = periods.four;
  endfunction

  function automatic bit step_due();
    logic [PERIOD_W:0] nxt;
    nxt = {1'b0, ticks} + 1'b1;
    if (nxt >= {1'b0, step_len}) begin
      restart_interval();
      return 1'b1;
    end
    ticks = nxt[PERIOD_W-1:0];
    return 1'b0;
  endfunction

  function automatic void resume_chaser();
    is_paused = 1'b0;
    drive = pat_single;
    restart_interval();
  endfunction

  function automatic result_t chaser_update(op_t op, logic [KEY_W-1:0] keys);
    result_t          r;
    logic [LED_W-1:0] p;
    r.beep_valid = 1'b0;
    r.beep_tone = TONE_ZERO;
    if (op == OP_TICK) begin
      if (in_dual) begin
        if (step_due()) begin
          p = pat_dual;
          if (toward_mid) p = ((p & DUAL_UPPER) >> 1) | ((p & DUAL_LOWER) << 1);
          else p = ((p & DUAL_UPPER) << 1) | ((p & DUAL_LOWER) >> 1);
          pat_dual = p;
          if (p == DUAL_MID || p == DUAL_RESET) toward_mid = ~toward_mid;
          drive = pat_dual;
        end
      end else if (!is_paused) begin
        if (step_due()) begin
          pat_single = pat_single << 1;
          if (pat_single == LEDS_OFF) pat_single = SINGLE_RESET;
          drive = pat_single;
        end
      end
    end else if (keys != '0) begin
      if (keys[KEY_RESUME] && is_paused && !in_dual) resume_chaser();
      if (keys[KEY_PAUSE] && !is_paused && !in_dual) begin
        is_paused = 1'b1;
        drive = LEDS_OFF;
      end
      if (keys[KEY_FASTER] && cur_speed < SPEED_TOP) cur_speed = cur_speed + 1'b1;
      if (keys[KEY_SLOWER] && cur_speed > SPEED_MIN) cur_speed = cur_speed - 1'b1;
      if (keys[KEY_DUAL_ON] && !in_dual) begin
        in_dual = 1'b1;
        is_paused = 1'b1;
        pat_dual = DUAL_RESET;
        toward_mid = 1'b1;
        drive = pat_dual;
        restart_interval();
      end
      if (keys[KEY_DUAL_OFF] && in_dual) begin
        in_dual = 1'b0;
        resume_chaser();
      end
      r.beep_valid = 1'b1;
      if (keys == MASK_K1) r.beep_tone = TONE_ZERO;
      else if (keys == MASK_K2) r.beep_tone = TONE_ONE;
      else if (keys == MASK_K3) r.beep_tone = TONE_TWO;
      else if (keys == MASK_K4) r.beep_tone = TONE_THREE;
      else r.beep_tone = TONE_ONE;
    end
    r.leds = drive;
    r.speed_level = cur_speed;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (chaser_results.size() == 0) begin
        note_failure($sformatf("unexpected result leds=%h beep=%b tone=%0d speed=%0d",
                               out_leds, out_beep_valid, out_beep_tone, out_speed_level));
      end else begin
        want = chaser_results.pop_front();
        if (out_leds !== want.leds || out_beep_valid !== want.beep_valid ||
            out_beep_tone !== want.beep_tone || out_speed_level !== want.speed_level)
          note_failure($sformatf(
            "result %0d: leds %h/%h beep %b/%b tone %0d/%0d speed %0d/%0d (exp/act)",
            results_seen, want.leds, out_leds, want.beep_valid, out_beep_valid,
            want.beep_tone, out_beep_tone, want.speed_level, out_speed_level));
      end
    end
  end

  // receiver: random stalls plus long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_item(input op_t op, input logic [KEY_W-1:0] keys);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_keys <= keys;
    do @(posedge clk); while (!in_ready);
    chaser_results.push_back(chaser_update(op, keys));
    items_sent++;
    if (op == OP_KEY) presses_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chaser_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_periods(input logic [PERIOD_W-1:0] p1, input logic [PERIOD_W-1:0] p2,
                               input logic [PERIOD_W-1:0] p3, input logic [PERIOD_W-1:0] p4);
    logic [PERIOD_W-1:0] vals[4];
    vals = '{p1, p2, p3, p4};
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[1:0];
      cfg_wdata <= vals[i];
      @(posedge clk);
      case (i[1:0])
        CFG_PERIOD_ONE:   periods.one = vals[i];
        CFG_PERIOD_TWO:   periods.two = vals[i];
        CFG_PERIOD_THREE: periods.three = vals[i];
        default:          periods.four = vals[i];
      endcase
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic test_key_actions();
    send_idle_pct = 30;
    recv_idle_pct = 30;
    send_item(OP_TICK, '0);
    send_item(OP_KEY, MASK_K2);
    send_item(OP_TICK, '0);
    send_item(OP_KEY, MASK_K1);
    repeat (4) send_item(OP_KEY, MASK_K3);
    repeat (4) send_item(OP_KEY, MASK_K4);
    send_item(OP_KEY, '0);
    send_item(OP_KEY, 6'h3F);
  endtask

  task automatic test_dual_mode();
    wait_idle();
    write_periods(16'd1, 16'd1, 16'd1, 16'd1);
    send_item(OP_KEY, MASK_K1 << KEY_DUAL_ON);
    send_item(OP_KEY, MASK_K1);
    send_item(OP_KEY, MASK_K2);
    repeat (6) send_item(OP_TICK, '0);
    send_item(OP_KEY, MASK_K1 << KEY_DUAL_OFF);
  endtask

  task automatic test_zero_period();
    wait_idle();
    write_periods(16'd0, 16'd2, 16'd3, 16'hFFFF);
    repeat (4) send_item(OP_TICK, '0);
  endtask

  task automatic test_random_traffic(input int n, input int unsigned s_pct,
                                     input int unsigned r_pct,
                                     input logic [PERIOD_W-1:0] p1,
                                     input logic [PERIOD_W-1:0] p2,
                                     input logic [PERIOD_W-1:0] p3,
                                     input logic [PERIOD_W-1:0] p4);
    int unsigned      pick;
    logic [KEY_W-1:0] k;
    wait_idle();
    write_periods(p1, p2, p3, p4);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_item(OP_TICK, KEY_W'($urandom_range(63)));
      end else begin
        if (pick < 88) k = MASK_K1 << $urandom_range(KEY_W-1);
        else if (pick < 97) k = KEY_W'($urandom_range(63));
        else k = '0;
        send_item(OP_KEY, k);
      end
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 80;
    repeat (40) send_item(OP_TICK, KEY_W'($urandom_range(63)));
  endtask

  initial begin
    periods = '{one: PERIOD_ONE_RST, two: PERIOD_TWO_RST,
                three: PERIOD_THREE_RST, four: PERIOD_FOUR_RST};
    pat_single = SINGLE_RESET;
    pat_dual = DUAL_RESET;
    toward_mid = 1'b1;
    is_paused = 1'b0;
    in_dual = 1'b0;
    cur_speed = SPEED_MIN;
    ticks = '0;
    step_len = PERIOD_ONE_RST;
    drive = SINGLE_RESET;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_key_actions();
    test_dual_mode();
    test_zero_period();
    test_random_traffic(270, 11, 80, 16'd1, 16'd2, 16'd3, 16'hFFFF);
    test_random_traffic(270, 80, 11, PERIOD_W'($urandom_range(1, 6)),
                        PERIOD_W'($urandom_range(1, 6)), PERIOD_W'($urandom_range(1, 6)),
                        PERIOD_W'($urandom_range(1, 6)));
    test_random_traffic(270, 0, 0, 16'd1, 16'd1, 16'd2, 16'd2);
    test_backpressure();
    wait_idle();
    repeat (6) @(posedge clk);
    if (chaser_results.size() != 0)
      note_failure($sformatf("%0d results never arrived", chaser_results.size()));

    $display("Sent %0d items (%0d key presses), checked %0d results, %0d mismatches.",
             items_sent, presses_sent, results_seen, mismatches);
    $display("Covered pause/resume, speed limits, dual mode, period extremes, stalls.");
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire
